FILE: hw/rtl/ezr_pkg.sv
`default_nettype none
package ezr_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int CORDIC_STEPS   = 16;

    localparam int FIELD_BITS = 16;
    localparam int PHASE_BITS = 32;
    localparam int WORK_FRAC  = 30;
    localparam int Q30_BITS   = 32;
    localparam int SUM_BITS   = Q30_BITS + 1;
    localparam int CORD_BITS  = 34;

    // cordic lane: fold, steps, sign restore; merge: three stages
    localparam int LANE_LAT = CORDIC_STEPS + 2;
    localparam int PIPE_LAT = LANE_LAT + 3;

    localparam logic signed [CORD_BITS-1:0] CORDIC_K = CORD_BITS'(652032875);

    typedef logic signed [FIELD_BITS-1:0] field_t;
    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [Q30_BITS-1:0]   q30_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic signed [CORD_BITS-1:0]  cord_t;

    typedef struct packed {
        field_t roll_angle;
        field_t pitch_angle;
        field_t yaw_angle;
    } angles_t;

    typedef struct packed {
        field_t m00;
        field_t m01;
        field_t m02;
        field_t m10;
        field_t m11;
        field_t m12;
        field_t m20;
        field_t m21;
        field_t m22;
    } matrix_t;

    // atan(2^-i) in units of 2^-32 of a full turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // q2.30 product, rounded half up
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [2*Q30_BITS-1:0] p;
        p = a * b;
        p = p + ((2*Q30_BITS)'(1) <<< (WORK_FRAC - 1));
        return Q30_BITS'(p >>> WORK_FRAC);
    endfunction

    // round to output precision and clamp to plus or minus one
    function automatic field_t to_field(input sum_t s);
        logic signed [SUM_BITS:0] r;
        logic signed [SUM_BITS:0] one;
        one = (SUM_BITS+1)'(1) <<< COEF_FRAC_BITS;
        r   = (SUM_BITS+1)'(s) + ((SUM_BITS+1)'(1) <<< (WORK_FRAC - COEF_FRAC_BITS - 1));
        r   = r >>> (WORK_FRAC - COEF_FRAC_BITS);
        if (r > one) begin
            r = one;
        end
        if (r < -one) begin
            r = -one;
        end
        return r[FIELD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ezr_if.sv
`default_nettype none
interface ezr_angles_if;
    import ezr_pkg::*;
    logic    valid;
    logic    ready;
    angles_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ezr_matrix_if;
    import ezr_pkg::*;
    logic    valid;
    logic    ready;
    matrix_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ezr_cordic_lane.sv
`default_nettype none
module ezr_cordic_lane (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire ezr_pkg::angle_t angle,
    output ezr_pkg::q30_t      sin_q,
    output ezr_pkg::q30_t      cos_q
);
    import ezr_pkg::*;

    cord_t x_reg [0:CORDIC_STEPS];
    cord_t y_reg [0:CORDIC_STEPS];
    cord_t z_reg [0:CORDIC_STEPS];
    logic  flip_reg [0:CORDIC_STEPS];
    q30_t  sin_reg;
    q30_t  cos_reg;

    logic signed [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0]        folded;
    logic                         flip;

    // angle to phase, fold second and third quadrant by half a turn
    always_comb
    begin
        phase  = PHASE_BITS'(angle) <<< (PHASE_BITS - ANGLE_BITS);
        flip   = (phase[PHASE_BITS-1:PHASE_BITS-2] == 2'b01) ||
                 (phase[PHASE_BITS-1:PHASE_BITS-2] == 2'b10);
        folded = phase ^ {flip, {(PHASE_BITS-1){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_K;
            y_reg[0]    <= '0;
            z_reg[0]    <= CORD_BITS'(signed'(folded));
            flip_reg[0] <= flip;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam cord_t ATAN_I = CORD_BITS'(atan_turn(i));
        cord_t xs;
        cord_t ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CORD_BITS-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // undo the fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (flip_reg[CORDIC_STEPS])
            begin
                sin_reg <= Q30_BITS'(-y_reg[CORDIC_STEPS]);
                cos_reg <= Q30_BITS'(-x_reg[CORDIC_STEPS]);
            end
            else
            begin
                sin_reg <= Q30_BITS'(y_reg[CORDIC_STEPS]);
                cos_reg <= Q30_BITS'(x_reg[CORDIC_STEPS]);
            end
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ezr_merge.sv
`default_nettype none
module ezr_merge (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire ezr_pkg::q30_t sr,
    input  wire ezr_pkg::q30_t cr,
    input  wire ezr_pkg::q30_t sp,
    input  wire ezr_pkg::q30_t cp,
    input  wire ezr_pkg::q30_t sy,
    input  wire ezr_pkg::q30_t cy,
    output ezr_pkg::matrix_t   result
);
    import ezr_pkg::*;

    q30_t cysp_reg, sysp_reg, cycp_reg, sycp_reg, sycr_reg, sysr_reg;
    q30_t cycr_reg, cysr_reg, cpsr_reg, cpcr_reg, nsp_reg, sr_reg, cr_reg;
    q30_t m01a_reg, m02a_reg, m11a_reg, m12a_reg;
    q30_t cycp2_reg, sycp2_reg, sycr2_reg, sysr2_reg, cycr2_reg, cysr2_reg;
    q30_t cpsr2_reg, cpcr2_reg, nsp2_reg;
    matrix_t result_reg;

    // first products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cysp_reg <= mul_q30(cy, sp);
            sysp_reg <= mul_q30(sy, sp);
            cycp_reg <= mul_q30(cy, cp);
            sycp_reg <= mul_q30(sy, cp);
            sycr_reg <= mul_q30(sy, cr);
            sysr_reg <= mul_q30(sy, sr);
            cycr_reg <= mul_q30(cy, cr);
            cysr_reg <= mul_q30(cy, sr);
            cpsr_reg <= mul_q30(cp, sr);
            cpcr_reg <= mul_q30(cp, cr);
            nsp_reg  <= -sp;
            sr_reg   <= sr;
            cr_reg   <= cr;
        end
    end

    // triple products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m01a_reg  <= mul_q30(cysp_reg, sr_reg);
            m02a_reg  <= mul_q30(cysp_reg, cr_reg);
            m11a_reg  <= mul_q30(sysp_reg, sr_reg);
            m12a_reg  <= mul_q30(sysp_reg, cr_reg);
            cycp2_reg <= cycp_reg;
            sycp2_reg <= sycp_reg;
            sycr2_reg <= sycr_reg;
            sysr2_reg <= sysr_reg;
            cycr2_reg <= cycr_reg;
            cysr2_reg <= cysr_reg;
            cpsr2_reg <= cpsr_reg;
            cpcr2_reg <= cpcr_reg;
            nsp2_reg  <= nsp_reg;
        end
    end

    // sums, rounding and clamping
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.m00 <= to_field(SUM_BITS'(cycp2_reg));
            result_reg.m01 <= to_field(SUM_BITS'(m01a_reg) - SUM_BITS'(sycr2_reg));
            result_reg.m02 <= to_field(SUM_BITS'(m02a_reg) + SUM_BITS'(sysr2_reg));
            result_reg.m10 <= to_field(SUM_BITS'(sycp2_reg));
            result_reg.m11 <= to_field(SUM_BITS'(m11a_reg) + SUM_BITS'(cycr2_reg));
            result_reg.m12 <= to_field(SUM_BITS'(m12a_reg) - SUM_BITS'(cysr2_reg));
            result_reg.m20 <= to_field(SUM_BITS'(nsp2_reg));
            result_reg.m21 <= to_field(SUM_BITS'(cpsr2_reg));
            result_reg.m22 <= to_field(SUM_BITS'(cpcr2_reg));
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/euler_zyx_to_rotation_matrix.sv
`default_nettype none
// channel   dir  payload
// angles    in   roll_angle, pitch_angle, yaw_angle (binary angles)
// matrix    out  m00..m22 (signed q2.14)
//
// one request accepted per cycle unless a stalled output holds the pipeline;
// data passes the pipelined cordic lanes, then the three product/sum stages
// rst_n clears only the valid bits of the pipeline
// a stalled result at the output holds the whole pipeline; input ready
// is high whenever the last stage is empty or being taken
module euler_zyx_to_rotation_matrix (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ezr_angles_if.sink  angles,
    ezr_matrix_if.source matrix
);
    import ezr_pkg::*;

    logic [PIPE_LAT-1:0] valid_reg;
    logic                en;
    q30_t                sr, cr, sp, cp, sy, cy;

    // pipeline advances unless a result is stuck at the output
    assign en           = !valid_reg[PIPE_LAT-1] || matrix.ready;
    assign angles.ready = en;
    assign matrix.valid = valid_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], angles.valid};
        end
    end

    // one cordic lane per angle
    ezr_cordic_lane u_roll (
        .clk   (clk),
        .en    (en),
        .angle (angle_t'(angles.data.roll_angle)),
        .sin_q (sr),
        .cos_q (cr)
    );

    ezr_cordic_lane u_pitch (
        .clk   (clk),
        .en    (en),
        .angle (angle_t'(angles.data.pitch_angle)),
        .sin_q (sp),
        .cos_q (cp)
    );

    ezr_cordic_lane u_yaw (
        .clk   (clk),
        .en    (en),
        .angle (angle_t'(angles.data.yaw_angle)),
        .sin_q (sy),
        .cos_q (cy)
    );

    // combine lane results into the matrix
    ezr_merge u_merge (
        .clk    (clk),
        .en     (en),
        .sr     (sr),
        .cr     (cr),
        .sp     (sp),
        .cp     (cp),
        .sy     (sy),
        .cy     (cy),
        .result (matrix.data)
    );

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        angles.ready == (!matrix.valid || matrix.ready))
        else $error("input ready does not follow output stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (angles.valid && angles.ready) |=> valid_reg[0])
        else $error("accepted request not in first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (matrix.valid && !matrix.ready) |=> $stable(valid_reg))
        else $error("pipeline moved during output stall");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        matrix.valid |-> (matrix.data.m00 <= 16'sd16384) &&
                         (matrix.data.m00 >= -16'sd16384) &&
                         (matrix.data.m11 <= 16'sd16384) &&
                         (matrix.data.m11 >= -16'sd16384))
        else $error("matrix entry beyond unity");

endmodule
`default_nettype wire
